>>> design/dpm_pkg.sv
package dpm_pkg;

    // Input item: temperature and humidity, both signed tenths
    typedef struct packed {
        logic signed [11:0] temperature_tenths;
        logic signed [11:0] humidity_tenths;
    } t_dpm_in;

    // Result item
    typedef struct packed {
        logic signed [11:0] dew_point_tenths;
        logic               humidity_error;
    } t_dpm_out;

    // Magnus coefficients in hundredths, and 10*B in hundredths
    localparam logic [11:0] COEF_WATER   = 12'd1762;
    localparam logic [11:0] COEF_ICE     = 12'd2246;
    localparam logic [18:0] BASE10_WATER = 19'd243120;
    localparam logic [18:0] BASE10_ICE   = 19'd272620;

    // ln(2) in Q24, log2(1000) in Q24 (same table and interpolation)
    localparam logic [23:0] LN2_Q24      = 24'd11629080;
    localparam logic [29:0] LOG2_1000    = 30'd167195816;

    // floor(x/10) for x < 2^12 as (x * TENTH_RECIP) >> 16
    localparam logic [12:0] TENTH_RECIP  = 13'd6554;

    localparam logic [10:0] DEW_LIMIT    = 11'd2000;

    // log2(1 + k/16), k = 0..16, Q24
    localparam logic [24:0] LOG2_TAB [17] = '{
        25'd0,        25'd1467383,  25'd2850868,  25'd4159533,  25'd5401057,
        25'd6581994,  25'd7707983,  25'd8783912,  25'd9814042,  25'd10802114,
        25'd11751428, 25'd12664911, 25'd13545168, 25'd14394532, 25'd15215099,
        25'd16008758, 25'd16777216
    };

endpackage

>>> design/dpm_div.sv
module dpm_div import dpm_pkg::*; #(
    parameter int NW = 39,
    parameter int DW = 19,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    // One quotient bit per stage, restoring, MSB first
    logic          r_vld [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_den [NW];
    logic [TW-1:0] r_tag [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic          w_vld;
        logic [DW-1:0] w_rem;
        logic [NW-1:0] w_nq;
        logic [DW-1:0] w_den;
        logic [TW-1:0] w_tag;
        logic [DW:0]   w_trial;
        logic [DW-1:0] n_rem;
        logic          n_bit;

        if (s == 0) begin : g_first
            assign w_vld = i_vld;
            assign w_rem = '0;
            assign w_nq  = i_num;
            assign w_den = i_den;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_vld = r_vld[s-1];
            assign w_rem = r_rem[s-1];
            assign w_nq  = r_nq[s-1];
            assign w_den = r_den[s-1];
            assign w_tag = r_tag[s-1];
        end

        // Shift in the next numerator bit, subtract if it fits
        always_comb begin
            w_trial = {w_rem, w_nq[NW-1]};
            if (w_trial >= {1'b0, w_den}) begin
                n_rem = DW'(w_trial - {1'b0, w_den});
                n_bit = 1'b1;
            end else begin
                n_rem = w_trial[DW-1:0];
                n_bit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
            r_rem[s] <= n_rem;
            r_nq[s]  <= {w_nq[NW-2:0], n_bit};
            r_den[s] <= w_den;
            r_tag[s] <= w_tag;
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_quo = r_nq[NW-1];
    assign o_tag = r_tag[NW-1];

    // Remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_rem[0] < r_den[0] || r_den[0] == '0))
        else $error("divider remainder out of bound");

    a_vld_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ##(NW-1) o_vld)
        else $error("divider lost an item");

    a_tag_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ##(NW-1) (o_tag == $past(r_tag[0], NW-1)))
        else $error("divider tag corrupted");

endmodule

>>> design/dew_point_magnus_core.sv
// Dew point pipeline: accepts one item every cycle, busy is never raised.
// Most of its stages are two bit-per-stage dividers: the Magnus term and the final ratio.
// Synchronous active-low reset clears all valid bits; data registers keep junk.
// Each result shows on o_result for one cycle with o_done; the receiver cannot stall.
module dew_point_magnus_core import dpm_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dpm_in  i_item,
    output logic     o_done,
    output t_dpm_out o_result
);

    localparam int F   = FRACTION_BITS;
    localparam int NW1 = 23 + F;        // |c*T| << F
    localparam int DW1 = 19;            // 10*(B +/- 100*Tq), minus for T < 0
    localparam int AW  = F + 10;        // a, ln in Q(F), signed
    localparam int TW1 = AW + 3;
    localparam int NW2 = F + 28;        // 10*B*|a|
    localparam int DW2 = F + 16;        // 100*b, positive part
    localparam int BW  = F + 17;        // 100*b, signed

    assign busy = 1'b0;

    // Stage A: sign, range, and leading-one of humidity
    logic        r_a_vld, r_a_err, r_a_tneg, r_a_ice;
    logic [11:0] r_a_tmag;
    logic [10:0] r_a_h;
    logic [3:0]  r_a_e;
    logic [3:0]  n_a_e;

    always_comb begin
        n_a_e = '0;
        for (int i = 1; i < 11; i++) begin
            if (i_item.humidity_tenths[i]) begin
                n_a_e = 4'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
        r_a_err  <= (i_item.humidity_tenths <= 12'sd0);
        r_a_tneg <= i_item.temperature_tenths[11];
        r_a_ice  <= (i_item.temperature_tenths <= 12'sd0);
        r_a_tmag <= i_item.temperature_tenths[11] ? 12'(-i_item.temperature_tenths)
                                                  : i_item.temperature_tenths;
        r_a_h    <= i_item.humidity_tenths[10:0];
        r_a_e    <= n_a_e;
    end

    // Stage B: |c*T|, |T|/10, normalized fraction
    logic        r_b_vld, r_b_err, r_b_tneg, r_b_ice;
    logic [22:0] r_b_num1;
    logic [8:0]  r_b_tq;
    logic [3:0]  r_b_k, r_b_e;
    logic [19:0] r_b_r;
    logic [24:0] n_b_tq;
    logic [34:0] n_b_sh;

    always_comb begin
        n_b_tq = r_a_tmag * TENTH_RECIP;
        n_b_sh = {24'd0, r_a_h} << (5'd24 - 5'(r_a_e));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_err  <= r_a_err;
        r_b_tneg <= r_a_tneg;
        r_b_ice  <= r_a_ice;
        r_b_num1 <= (r_a_ice ? COEF_ICE : COEF_WATER) * r_a_tmag;
        r_b_tq   <= n_b_tq[24:16];
        r_b_k    <= n_b_sh[23:20];
        r_b_r    <= n_b_sh[19:0];
        r_b_e    <= r_a_e;
    end

    // Stage C: divisor, table read and interpolation product
    logic        r_c_vld, r_c_err, r_c_tneg, r_c_ice;
    logic [22:0] r_c_num1;
    logic [18:0] r_c_den1;
    logic [24:0] r_c_tab;
    logic [20:0] r_c_frac;
    logic [3:0]  r_c_e;
    logic [18:0] n_c_base;
    logic [17:0] n_c_tq1k;
    logic [20:0] n_c_d;
    logic [40:0] n_c_prod;

    always_comb begin
        n_c_base = r_b_ice ? BASE10_ICE : BASE10_WATER;
        n_c_tq1k = r_b_tq * 10'd1000;
        n_c_d    = 21'(LOG2_TAB[5'(r_b_k) + 5'd1] - LOG2_TAB[r_b_k]);
        n_c_prod = n_c_d * r_b_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_err  <= r_b_err;
        r_c_tneg <= r_b_tneg;
        r_c_ice  <= r_b_ice;
        r_c_num1 <= r_b_num1;
        r_c_den1 <= r_b_tneg ? n_c_base - 19'(n_c_tq1k) : n_c_base + 19'(n_c_tq1k);
        r_c_tab  <= LOG2_TAB[r_b_k];
        r_c_frac <= n_c_prod[40:20];
        r_c_e    <= r_b_e;
    end

    // Stage D: log2(H) - log2(1000) in Q24
    logic               r_d_vld, r_d_err, r_d_tneg, r_d_ice;
    logic [22:0]        r_d_num1;
    logic [18:0]        r_d_den1;
    logic signed [29:0] r_d_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_err  <= r_c_err;
        r_d_tneg <= r_c_tneg;
        r_d_ice  <= r_c_ice;
        r_d_num1 <= r_c_num1;
        r_d_den1 <= r_c_den1;
        r_d_diff <= $signed({2'b00, r_c_e, 24'd0} + 30'(r_c_tab) + 30'(r_c_frac)
                            - LOG2_1000);
    end

    // Stage E: times ln2, split in two partial products
    logic               r_e_vld, r_e_err, r_e_tneg, r_e_ice;
    logic [22:0]        r_e_num1;
    logic [18:0]        r_e_den1;
    logic [39:0]        r_e_pp_lo;
    logic signed [38:0] r_e_pp_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_err   <= r_d_err;
        r_e_tneg  <= r_d_tneg;
        r_e_ice   <= r_d_ice;
        r_e_num1  <= r_d_num1;
        r_e_den1  <= r_d_den1;
        r_e_pp_lo <= r_d_diff[15:0] * LN2_Q24;
        r_e_pp_hi <= $signed(r_d_diff[29:16]) * $signed({1'b0, LN2_Q24});
    end

    // Stage F: combine and scale to Q(F), floor
    logic               r_f_vld, r_f_err, r_f_tneg, r_f_ice;
    logic [22:0]        r_f_num1;
    logic [18:0]        r_f_den1;
    logic signed [AW-1:0] r_f_ln;
    logic signed [55:0] n_f_prod;
    logic signed [55:0] n_f_shift;

    always_comb begin
        n_f_prod  = ($signed(56'(r_e_pp_hi)) <<< 16) + $signed({16'd0, r_e_pp_lo});
        n_f_shift = n_f_prod >>> (48 - F);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
        r_f_err  <= r_e_err;
        r_f_tneg <= r_e_tneg;
        r_f_ice  <= r_e_ice;
        r_f_num1 <= r_e_num1;
        r_f_den1 <= r_e_den1;
        r_f_ln   <= n_f_shift[AW-1:0];
    end

    // Magnus term magnitude: |c*T| * 2^F / (10*(B+/-Tq)), minus for T < 0
    logic           w_q1_vld;
    logic [NW1-1:0] w_q1;
    logic [TW1-1:0] w_q1_tag;

    dpm_div #(.NW(NW1), .DW(DW1), .TW(TW1)) u_div_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_f_vld),
        .i_num   ({r_f_num1, {F{1'b0}}}),
        .i_den   (r_f_den1),
        .i_tag   ({r_f_err, r_f_tneg, r_f_ice, r_f_ln}),
        .o_vld   (w_q1_vld),
        .o_quo   (w_q1),
        .o_tag   (w_q1_tag)
    );

    // Stage G: a = ln + signed term
    logic                 r_g_vld, r_g_err, r_g_ice;
    logic signed [AW-1:0] r_g_a;
    logic signed [AW-1:0] n_g_term;

    always_comb begin
        n_g_term = $signed({1'b0, w_q1[AW-2:0]});
        if (w_q1_tag[AW+1]) begin
            n_g_term = -n_g_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= w_q1_vld;
        end
        r_g_err <= w_q1_tag[AW+2];
        r_g_ice <= w_q1_tag[AW];
        r_g_a   <= $signed(w_q1_tag[AW-1:0]) + n_g_term;
    end

    // Stage H: 10*B*|a| and 100*b = c*2^F - 100*a
    logic                 r_h_vld, r_h_err, r_h_aneg;
    logic [NW2-1:0]       r_h_num2;
    logic signed [BW-1:0] r_h_b100;
    logic [AW-2:0]        n_h_amag;
    logic [11:0]          n_h_coef;

    always_comb begin
        n_h_amag = r_g_a[AW-1] ? (AW-1)'(-r_g_a) : r_g_a[AW-2:0];
        n_h_coef = r_g_ice ? COEF_ICE : COEF_WATER;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
        r_h_err  <= r_g_err;
        r_h_aneg <= r_g_a[AW-1];
        r_h_num2 <= (r_g_ice ? BASE10_ICE : BASE10_WATER) * n_h_amag;
        r_h_b100 <= $signed({5'd0, n_h_coef, {F{1'b0}}})
                    - $signed(BW'(r_g_a) * $signed(BW'(100)));
    end

    // Final ratio; non-positive 100*b saturates high
    logic       w_b_ok;
    logic       w_q2_vld;
    logic [NW2-1:0] w_q2;
    logic [2:0] w_q2_tag;

    assign w_b_ok = (r_h_b100 > $signed(BW'(0)));

    dpm_div #(.NW(NW2), .DW(DW2), .TW(3)) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_h_vld),
        .i_num   (r_h_num2),
        .i_den   (w_b_ok ? r_h_b100[DW2-1:0] : DW2'(1)),
        .i_tag   ({r_h_err, r_h_aneg, !w_b_ok}),
        .o_vld   (w_q2_vld),
        .o_quo   (w_q2),
        .o_tag   (w_q2_tag)
    );

    // Output stage: error, saturation, sign
    logic        r_done;
    t_dpm_out    r_result;
    t_dpm_out    n_result;
    logic [10:0] n_mag;

    always_comb begin
        n_mag = (w_q2 > NW2'(DEW_LIMIT)) ? DEW_LIMIT : w_q2[10:0];
        n_result.humidity_error = w_q2_tag[2];
        if (w_q2_tag[2]) begin
            n_result.dew_point_tenths = '0;
        end else if (w_q2_tag[0]) begin
            n_result.dew_point_tenths = $signed({1'b0, DEW_LIMIT});
        end else if (w_q2_tag[1]) begin
            n_result.dew_point_tenths = -$signed({1'b0, n_mag});
        end else begin
            n_result.dew_point_tenths = $signed({1'b0, n_mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_q2_vld;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.humidity_error |-> o_result.dew_point_tenths == 12'sd0)
        else $error("error item with nonzero dew point");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.dew_point_tenths <= 12'sd2000 &&
                    o_result.dew_point_tenths >= -12'sd2000))
        else $error("dew point outside saturation range");

    a_divisor_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld |-> r_f_den1 != '0)
        else $error("zero divisor for Magnus term");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |=> ##(2*F+58) o_done)
        else $error("item lost in pipeline");

endmodule
